### hdl/rle_prefix_integer_decoder_top_assert.svh
// Assertion macros used by the decoder datapath module.
`ifndef RLE_PREFIX_INTEGER_DECODER_TOP_ASSERT_SVH
`define RLE_PREFIX_INTEGER_DECODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define RPID_ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define RPID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RPID_ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define RPID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hdl/rpid_pkg.sv
package rpid_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_PREFIX = 3'd1,
        PH_CODE   = 3'd2,
        PH_SUFFIX = 3'd3,
        PH_DRAIN  = 3'd4
    } t_phase;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_HDR_ERR  = 2'd1;
    localparam logic [1:0] ST_TOO_FEW  = 2'd2;

    localparam logic [7:0] MAX_PREFIX  = 8'd4;

    typedef struct packed {
        logic accept;
        logic emit;
        logic stream_end;
        logic final_load;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic start_emit;
        logic emit_final;
        logic out_free;
    } t_sts;

endpackage

### hdl/rpid_ctrl.sv
module rpid_ctrl
    import rpid_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_last_byte,
    input  t_sts i_sts,
    output logic o_stall,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_FINAL
    } t_state;

    t_state r_state;
    logic   r_last;

    always_comb begin
        o_cmd = '0;
        o_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_valid;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.stream_end = r_last && i_sts.emit_final;
                o_cmd.clear = i_sts.out_free && r_last && i_sts.emit_final;
            end
            S_FINAL: begin
                o_cmd.final_load = i_sts.out_free;
                o_cmd.clear = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_last <= i_last_byte;
                        if (i_sts.start_emit) begin
                            r_state <= S_EMIT;
                        end else if (i_last_byte) begin
                            r_state <= S_FINAL;
                        end
                    end
                end
                S_EMIT: begin
                    if (i_sts.out_free && i_sts.emit_final) begin
                        r_state <= S_IDLE;
                    end
                end
                S_FINAL: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/rpid_datapath.sv
`include "rle_prefix_integer_decoder_top_assert.svh"

module rpid_datapath
    import rpid_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_stall,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_valid,
    output logic [31:0] o_value,
    output logic        o_value_valid,
    output logic        o_run_last,
    output logic        o_stream_done,
    output logic [1:0]  o_status
);

    logic [31:0]         r_value_count;
    t_phase              r_phase;
    logic [31:0]         r_common;
    logic [2:0]          r_prefix_left;
    logic [1:0]          r_pos;
    logic [31:0]         r_accum;
    logic [1:0]          r_width;
    logic [1:0]          r_suffix_left;
    logic [6:0]          r_run;
    logic [31:0]         r_run_value;
    logic [COUNT_BITS-1:0] r_emitted;
    logic                r_hdr_err;

    t_phase              n_phase;
    logic [31:0]         n_common;
    logic [2:0]          n_prefix_left;
    logic [1:0]          n_pos;
    logic [31:0]         n_accum;
    logic [1:0]          n_width;
    logic [1:0]          n_suffix_left;
    logic [6:0]          n_run;
    logic [31:0]         n_run_value;
    logic                n_hdr_err;

    logic                r_out_valid;
    logic [31:0]         r_out_value;
    logic                r_out_value_valid;
    logic                r_out_run_last;
    logic                r_out_done;
    logic [1:0]          r_out_status;

    logic [COUNT_BITS-1:0] target;
    logic [COUNT_BITS-1:0] emitted_inc;
    logic                active;
    logic                start_emit;
    logic [31:0]         byte_shifted;
    logic [31:0]         accum_or;
    logic [1:0]          final_status;

    assign target = COUNT_BITS'(r_value_count);
    assign emitted_inc = r_emitted + COUNT_BITS'(1);
    assign active = (r_emitted < target);
    assign byte_shifted = {24'd0, i_data_byte} << {r_pos, 3'b000};
    assign accum_or = r_accum | byte_shifted;

    always_comb begin
        n_phase = r_phase;
        n_common = r_common;
        n_prefix_left = r_prefix_left;
        n_pos = r_pos;
        n_accum = r_accum;
        n_width = r_width;
        n_suffix_left = r_suffix_left;
        n_run = r_run;
        n_run_value = r_run_value;
        n_hdr_err = r_hdr_err;
        start_emit = 1'b0;
        if (active) begin
            case (r_phase)
                PH_HEADER: begin
                    if (i_data_byte > MAX_PREFIX) begin
                        n_hdr_err = 1'b1;
                        n_phase = PH_DRAIN;
                    end else begin
                        n_common = '0;
                        n_prefix_left = i_data_byte[2:0];
                        n_pos = '0;
                        n_phase = (i_data_byte != 8'd0) ? PH_PREFIX : PH_CODE;
                    end
                end
                PH_PREFIX: begin
                    n_common = r_common | byte_shifted;
                    n_pos = r_pos + 2'd1;
                    n_prefix_left = r_prefix_left - 3'd1;
                    if (r_prefix_left == 3'd1) begin
                        n_phase = PH_CODE;
                    end
                end
                PH_CODE: begin
                    n_width = i_data_byte[1:0];
                    n_run = {1'b0, i_data_byte[7:2]} + 7'd1;
                    n_accum = '0;
                    if (i_data_byte[1:0] == 2'd0) begin
                        start_emit = 1'b1;
                        n_run_value = r_common;
                    end else begin
                        n_suffix_left = i_data_byte[1:0];
                        n_pos = '0;
                        n_phase = PH_SUFFIX;
                        start_emit = i_last_byte;
                        n_run_value = r_common << {i_data_byte[1:0], 3'b000};
                    end
                end
                PH_SUFFIX: begin
                    n_accum = accum_or;
                    n_pos = r_pos + 2'd1;
                    n_suffix_left = r_suffix_left - 2'd1;
                    n_run_value = (r_common << {r_width, 3'b000}) | accum_or;
                    if (r_suffix_left == 2'd1 || i_last_byte) begin
                        start_emit = 1'b1;
                        n_phase = PH_CODE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_comb begin
        if (target == '0) begin
            final_status = ST_OK;
        end else if (r_hdr_err) begin
            final_status = ST_HDR_ERR;
        end else if (r_emitted >= target) begin
            final_status = ST_OK;
        end else begin
            final_status = ST_TOO_FEW;
        end
    end

    assign o_sts.start_emit = start_emit;
    assign o_sts.emit_final = (r_run == 7'd1) || (emitted_inc == target);
    assign o_sts.out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_value_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_phase <= PH_HEADER;
            r_common <= '0;
            r_prefix_left <= '0;
            r_pos <= '0;
            r_accum <= '0;
            r_width <= '0;
            r_suffix_left <= '0;
            r_run <= '0;
            r_run_value <= '0;
            r_emitted <= '0;
            r_hdr_err <= 1'b0;
        end else if (i_cmd.accept) begin
            r_phase <= n_phase;
            r_common <= n_common;
            r_prefix_left <= n_prefix_left;
            r_pos <= n_pos;
            r_accum <= n_accum;
            r_width <= n_width;
            r_suffix_left <= n_suffix_left;
            r_run <= n_run;
            r_run_value <= n_run_value;
            r_hdr_err <= n_hdr_err;
        end else if (i_cmd.emit) begin
            r_emitted <= emitted_inc;
            r_run <= o_sts.emit_final ? 7'd0 : r_run - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.final_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_value <= r_run_value;
            r_out_value_valid <= 1'b1;
            r_out_run_last <= o_sts.emit_final;
            r_out_done <= i_cmd.stream_end;
            if (i_cmd.stream_end && emitted_inc < target) begin
                r_out_status <= ST_TOO_FEW;
            end else begin
                r_out_status <= ST_OK;
            end
        end else if (i_cmd.final_load) begin
            r_out_value <= '0;
            r_out_value_valid <= 1'b0;
            r_out_run_last <= 1'b1;
            r_out_done <= 1'b1;
            r_out_status <= final_status;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_value_valid = r_out_value_valid;
    assign o_run_last = r_out_run_last;
    assign o_stream_done = r_out_done;
    assign o_status = r_out_status;

    `RPID_ASSERT_HOLDS(a_done_is_run_last, i_clk, i_rst_n,
        !(r_out_valid && r_out_done) || r_out_run_last)
    `RPID_ASSERT_HOLDS(a_novalue_closes, i_clk, i_rst_n,
        !(r_out_valid && !r_out_value_valid) || r_out_done)
    `RPID_ASSERT_HOLDS(a_emit_has_run, i_clk, i_rst_n,
        !i_cmd.emit || (r_run != 7'd0 && active))
    `RPID_ASSERT_NEXT(a_final_clears, i_clk, i_rst_n,
        i_cmd.final_load, r_phase == PH_HEADER && r_emitted == '0)

endmodule

### hdl/rle_prefix_integer_decoder_top.sv
// A byte that starts a run moves the control to the emit state, which registers its
// results; a byte causing no result leaves the control idle. A byte causing n results
// stalls the input while they go out, one result per unstalled output cycle, set by the
// run emission loop. A stream-closing byte with no values goes through the final state
// for its single status result. Synchronous active-low reset clears the stream state,
// the output valid flag and the value count register to zero.
module rle_prefix_integer_decoder_top
    import rpid_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value,
    output logic        o_value_valid,
    output logic        o_run_last,
    output logic        o_stream_done,
    output logic [1:0]  o_status
);

    t_cmd cmd;
    t_sts sts;

    rpid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_byte (i_last_byte),
        .i_sts       (sts),
        .o_stall     (o_stall),
        .o_cmd       (cmd)
    );

    rpid_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_stall       (i_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_value       (o_value),
        .o_value_valid (o_value_valid),
        .o_run_last    (o_run_last),
        .o_stream_done (o_stream_done),
        .o_status      (o_status)
    );

endmodule

### dv/tb_rle_prefix_integer_decoder_top.sv
`timescale 1ns / 1ps

module tb_rle_prefix_integer_decoder_top;
    import rpid_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_BYTES    = 8;
    localparam int MAX_REPORTS    = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_stream_byte;

    typedef struct packed {
        logic [31:0] value;
        logic        value_valid;
        logic        run_last;
        logic        stream_done;
        logic [1:0]  status;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_value;
    logic        o_value_valid;
    logic        o_run_last;
    logic        o_stream_done;
    logic [1:0]  o_status;

    rle_prefix_integer_decoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_value       (o_value),
        .o_value_valid (o_value_valid),
        .o_run_last    (o_run_last),
        .o_stream_done (o_stream_done),
        .o_status      (o_status)
    );

    always #5 i_clk = ~i_clk;

    t_stream_byte stream_q[$];
    t_result      expected_q[$];
    t_result      run_q[$];

    int idle_pct = 27;
    int bytes_queued = 0;
    int bytes_in = 0;
    int values_out = 0;
    int closures = 0;
    int settings_used = 0;
    int errors = 0;
    int quiet_cycles = 0;
    logic in_taken = 1'b0;

    // Decoder state mirrored from the block.
    logic [31:0] count_cfg;
    t_phase      dec_phase;
    logic [31:0] common_val;
    logic [2:0]  pfx_left;
    logic [1:0]  byte_pos;
    logic [31:0] sfx_acc;
    logic [1:0]  sfx_width;
    logic [1:0]  sfx_left;
    logic [6:0]  run_len;
    logic [31:0] emitted;
    logic        hdr_err;

    function automatic void clear_stream();
        dec_phase  = PH_HEADER;
        common_val = '0;
        pfx_left   = '0;
        byte_pos   = '0;
        sfx_acc    = '0;
        sfx_width  = '0;
        sfx_left   = '0;
        run_len    = '0;
        emitted    = '0;
        hdr_err    = 1'b0;
    endfunction

    function automatic void emit_run(input logic [31:0] v);
        for (int i = 0; i < run_len && emitted < count_cfg; i++) begin
            run_q.insert(run_q.size(), t_result'({v, 1'b1, 1'b0, 1'b0, ST_OK}));
            emitted = emitted + 32'd1;
        end
        run_len = '0;
    endfunction

    function automatic logic [31:0] joined_value();
        return (common_val << {sfx_width, 3'b000}) | sfx_acc;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        logic [1:0] st;
        if (emitted < count_cfg) begin
            case (dec_phase)
                PH_HEADER: begin
                    if (b > MAX_PREFIX) begin
                        hdr_err   = 1'b1;
                        dec_phase = PH_DRAIN;
                    end else begin
                        common_val = '0;
                        pfx_left   = b[2:0];
                        byte_pos   = '0;
                        dec_phase  = (b != 8'd0) ? PH_PREFIX : PH_CODE;
                    end
                end
                PH_PREFIX: begin
                    common_val = common_val | (32'(b) << {byte_pos, 3'b000});
                    byte_pos   = byte_pos + 2'd1;
                    pfx_left   = pfx_left - 3'd1;
                    if (pfx_left == 3'd0) dec_phase = PH_CODE;
                end
                PH_CODE: begin
                    sfx_width = b[1:0];
                    run_len   = {1'b0, b[7:2]} + 7'd1;
                    sfx_acc   = '0;
                    if (sfx_width == 2'd0) begin
                        emit_run(common_val);
                    end else begin
                        sfx_left  = sfx_width;
                        byte_pos  = '0;
                        dec_phase = PH_SUFFIX;
                        if (last) emit_run(joined_value());
                    end
                end
                PH_SUFFIX: begin
                    sfx_acc  = sfx_acc | (32'(b) << {byte_pos, 3'b000});
                    byte_pos = byte_pos + 2'd1;
                    sfx_left = sfx_left - 2'd1;
                    if (sfx_left == 2'd0 || last) begin
                        emit_run(joined_value());
                        dec_phase = PH_CODE;
                    end
                end
                default: begin
                end
            endcase
        end
        if (last) begin
            if (count_cfg == '0) st = ST_OK;
            else if (hdr_err) st = ST_HDR_ERR;
            else if (emitted >= count_cfg) st = ST_OK;
            else st = ST_TOO_FEW;
            if (run_q.size() == 0) run_q.insert(0, t_result'('0));
            run_q[run_q.size() - 1].stream_done = 1'b1;
            run_q[run_q.size() - 1].status      = st;
            clear_stream();
        end
        if (run_q.size() != 0) run_q[run_q.size() - 1].run_last = 1'b1;
        foreach (run_q[i]) expected_q.insert(expected_q.size(), run_q[i]);
        run_q.delete();
    endfunction

    // Request driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (stream_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                {i_data_byte, i_last_byte} <= stream_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= i_rst_n && ($urandom_range(99) < idle_pct);
    end

    // Result monitor, prediction and watchdog.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        logic    out_taken;
        if (!i_rst_n) begin
            count_cfg = '0;
            clear_stream();
            in_taken = 1'b0;
        end else begin
            in_taken  = i_valid && !o_stall;
            out_taken = o_valid && !i_stall;
            if (out_taken) begin
                got = {o_value, o_value_valid, o_run_last, o_stream_done, o_status};
                if (got.value_valid) values_out++;
                if (got.stream_done) closures++;
                if (expected_q.size() == 0) begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: unexpected result value=%h vv=%b last=%b done=%b st=%0d",
                                 $time, got.value, got.value_valid, got.run_last,
                                 got.stream_done, got.status);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        if (errors < MAX_REPORTS)
                            $display("%0t: mismatch expected value=%h vv=%b last=%b done=%b",
                                     $time, want.value, want.value_valid, want.run_last,
                                     want.stream_done,
                                     " st=%0d, got value=%h vv=%b last=%b done=%b st=%0d",
                                     want.status, got.value, got.value_valid,
                                     got.run_last, got.stream_done, got.status);
                        errors++;
                    end
                end
            end
            if (in_taken) begin
                bytes_in++;
                decode_byte(i_data_byte, i_last_byte);
            end
            if (i_cfg_wr_en) count_cfg = i_cfg_wr_data;
            if (in_taken || out_taken || i_cfg_wr_en) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic last);
        stream_q.insert(stream_q.size(), t_stream_byte'({data, last}));
        bytes_queued++;
    endtask

    task automatic queue_stream();
        t_stream_byte enc_q[$];
        int n_pfx;
        int run;
        int w;
        int cut;
        n_pfx = $urandom_range(4);
        enc_q.insert(enc_q.size(), t_stream_byte'({8'(n_pfx), 1'b0}));
        repeat (n_pfx) enc_q.insert(enc_q.size(), t_stream_byte'({8'($urandom), 1'b0}));
        repeat ($urandom_range(1, 4)) begin
            w   = $urandom_range(3);
            run = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(7);
            enc_q.insert(enc_q.size(), t_stream_byte'({6'(run), 2'(w), 1'b0}));
            repeat (w) enc_q.insert(enc_q.size(), t_stream_byte'({8'($urandom), 1'b0}));
        end
        cut = ($urandom_range(3) == 0) ? $urandom_range(1, enc_q.size()) : enc_q.size();
        foreach (enc_q[i])
            if (i < cut) push_byte(enc_q[i].data, i == cut - 1);
    endtask

    task automatic queue_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) push_byte(8'($urandom), i == n - 1);
    endtask

    task automatic write_count(input logic [31:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_idle();
        while (stream_q.size() != 0 || i_valid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] phase_count [7];
        int goal;
        phase_count[0] = 32'd1;
        phase_count[1] = 32'hFFFF_FFFF;
        phase_count[2] = 32'($urandom_range(4, 40));
        phase_count[3] = 32'd0;
        phase_count[4] = 32'($urandom_range(1, 300));
        phase_count[5] = 32'($urandom_range(10, 80));
        phase_count[6] = 32'($urandom_range(2, 12));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Count still zero from reset: every byte is ignored and the stream succeeds.
        settings_used++;
        push_byte(8'h07, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFE, 1'b1);
        wait_idle();

        write_count(32'd100);
        // Full prefix, a maximal run with no suffix, then suffix widths of three and one bytes.
        push_byte(8'h04, 1'b0);
        repeat (4) push_byte(8'hFF, 1'b0);
        push_byte(8'hFC, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h7F, 1'b1);
        // Header over four.
        push_byte(8'h09, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b1);
        // Stream ends inside the prefix.
        push_byte(8'h02, 1'b0);
        push_byte(8'h34, 1'b1);
        // Code byte that is itself last, with a two-byte suffix missing.
        push_byte(8'h00, 1'b0);
        push_byte(8'h02, 1'b1);
        wait_idle();

        // Target reached partway through a run; the rest is ignored.
        write_count(32'd3);
        push_byte(8'h01, 1'b0);
        push_byte(8'hAB, 1'b0);
        push_byte(8'h0C, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_idle();

        for (int p = 0; p < 7; p++) begin
            idle_pct = (p == 2) ? 0 : 27;
            write_count(phase_count[p]);
            goal = bytes_queued + PHASE_BYTES;
            while (bytes_queued < goal) begin
                if ($urandom_range(4) == 0) queue_noise();
                else queue_stream();
            end
            wait_idle();
        end

        if (expected_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_q.size());
            errors++;
        end
        $display("Summary: %0d bytes decoded into %0d values and %0d stream closures,",
                 bytes_in, values_out, closures);
        $display("         across %0d value count settings with %0d failures.",
                 settings_used, errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/rpid_pkg.sv
hdl/rpid_ctrl.sv
hdl/rpid_datapath.sv
hdl/rle_prefix_integer_decoder_top.sv
dv/tb_rle_prefix_integer_decoder_top.sv
